>>> rtl/fbik_pkg.sv
`default_nettype none
package fbik_pkg;
    localparam int XW        = 17;
    localparam int LW        = 16;
    localparam int CNTW      = 13;
    localparam int CFG_IDX_W = 3;
    localparam int PXW       = 18;
    localparam int D2W       = 35;
    localparam int PW        = 34;
    localparam int SQW       = 32;
    localparam int NW        = 37;
    localparam int SQRT_W    = 29;
    localparam int RAD_W     = 2 * SQRT_W;
    localparam int DW        = 64;
    localparam int NUM_ATAN  = 24;
    localparam int ANG_GUARD = 4;
    localparam int N_SCALE   = 24;
    localparam int DIR_SCALE = 30;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] INV_PI_Q30  = 64'd341782638;
    localparam logic [CNTW-1:0] COUNT_MAX = 13'd8191;

    localparam logic [63:0] ATAN_Q30 [NUM_ATAN] = '{
        64'd843314857, 64'd497837830, 64'd263043837, 64'd133525158, 64'd67021687,
        64'd33543516, 64'd16775851, 64'd8388437, 64'd4194283, 64'd2097149,
        64'd1048576, 64'd524288, 64'd262144, 64'd131072, 64'd65536, 64'd32768,
        64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256, 64'd128
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_UPPER,
        CFG_LEFT_LOWER,
        CFG_RIGHT_LOWER,
        CFG_RIGHT_UPPER,
        CFG_BASE_OFFSET,
        CFG_CENTRE
    } t_cfg_idx;

    typedef struct packed {
        logic            vld;
        logic            ok;
        logic [CNTW-1:0] count;
    } t_arm_res;

    // Q30 constant to Q frac_bits, rounded half up
    function automatic logic [63:0] to_frac(input logic [63:0] q30, input int frac_bits);
        logic [63:0] rnd;
        rnd = 64'd1 << (29 - frac_bits);
        return (q30 + rnd) >> (30 - frac_bits);
    endfunction
endpackage
`default_nettype wire

>>> rtl/fbik_sqrt_cell.sv
`default_nettype none
module fbik_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                                     i_clk,
    input  logic [1:0][fbik_pkg::RAD_W-1:0]          i_rem,
    input  logic [1:0][fbik_pkg::SQRT_W-1:0]         i_root,
    output logic [1:0][fbik_pkg::RAD_W-1:0]          o_rem,
    output logic [1:0][fbik_pkg::SQRT_W-1:0]         o_root
);
    import fbik_pkg::*;

    logic [1:0][RAD_W-1:0]  n_rem;
    logic [1:0][SQRT_W-1:0] n_root;
    logic [1:0][RAD_W-1:0]  trial;
    logic [1:0][RAD_W-1:0]  r_rem;
    logic [1:0][SQRT_W-1:0] r_root;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            trial[k] = (RAD_W'(i_root[k]) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
            if (i_rem[k] >= trial[k]) begin
                n_rem[k]  = i_rem[k] - trial[k];
                n_root[k] = i_root[k] | (SQRT_W'(1) << BIT);
            end else begin
                n_rem[k]  = i_rem[k];
                n_root[k] = i_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

>>> rtl/fbik_cordic_cell.sv
`default_nettype none
module fbik_cordic_cell #(
    parameter int STAGE     = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                                              i_clk,
    input  logic signed [fbik_pkg::DW-1:0]                    i_x,
    input  logic signed [fbik_pkg::DW-1:0]                    i_y,
    input  logic signed [FRAC_BITS+fbik_pkg::ANG_GUARD-1:0]   i_z,
    output logic signed [fbik_pkg::DW-1:0]                    o_x,
    output logic signed [fbik_pkg::DW-1:0]                    o_y,
    output logic signed [FRAC_BITS+fbik_pkg::ANG_GUARD-1:0]   o_z
);
    import fbik_pkg::*;
    localparam int ZW = FRAC_BITS + ANG_GUARD;
    localparam logic signed [ZW-1:0] ATAN = ZW'(to_frac(ATAN_Q30[STAGE], FRAC_BITS));

    logic signed [DW-1:0] sx, sy, n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0] n_z, r_z;

    always_comb begin
        sx = i_x >>> STAGE;
        sy = i_y >>> STAGE;
        if (!i_y[DW-1] && (i_y != '0)) begin
            n_x = i_x + sy;
            n_y = i_y - sx;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - sy;
            n_y = i_y + sx;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

>>> rtl/fbik_arm.sv
`default_nettype none
module fbik_arm #(
    parameter int FRAC_BITS            = 16,
    parameter int CORDIC_STAGES        = 16,
    parameter int COUNTS_PER_HALF_TURN = 2048,
    parameter bit ADD_BASE             = 1'b0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [fbik_pkg::PXW-1:0]     i_px,
    input  logic signed [fbik_pkg::XW-1:0]      i_py,
    input  logic [fbik_pkg::LW-1:0]             i_upper,
    input  logic [fbik_pkg::LW-1:0]             i_lower,
    input  logic [fbik_pkg::CNTW-1:0]           i_centre,
    output fbik_pkg::t_arm_res                  o_res
);
    import fbik_pkg::*;
    localparam int ZW   = FRAC_BITS + ANG_GUARD;
    localparam int PRW  = ZW + 31;
    localparam int VW   = PRW - 15;
    localparam int CPW  = $clog2(COUNTS_PER_HALF_TURN + 1) + 1;
    localparam int MW   = VW + CPW;
    localparam int RNDW = MW - (FRAC_BITS + 15) + 1;
    localparam int CLW  = RNDW + 2;
    localparam logic signed [ZW-1:0]  PI_F      = ZW'(to_frac(PI_Q30, FRAC_BITS));
    localparam logic signed [ZW-1:0]  HALF_PI_F = ZW'(to_frac(HALF_PI_Q30, FRAC_BITS));
    localparam logic signed [CPW-1:0] CPHT      = CPW'(COUNTS_PER_HALF_TURN);
    localparam logic signed [30:0]    INV_PI    = 31'(INV_PI_Q30);
    localparam logic [MW:0]           RND_HALF  = (MW + 1)'(1) << (FRAC_BITS + 14);

    // stage 1: squares
    logic signed [2*PXW-1:0] px_sq;
    logic signed [2*XW-1:0]  py_sq;
    logic [LW:0]             len_sum;
    logic signed [LW:0]      len_dif;
    logic signed [2*LW+1:0]  dif_sq;
    logic [2*LW+1:0]         sum_sq;

    logic                    r_s1_vld, r_s1_zero;
    logic [D2W-1:0]          r_s1_px2, r_s1_py2, r_s1_s2, r_s1_df2;
    logic [SQW-1:0]          r_s1_u2, r_s1_w2;
    logic signed [PXW-1:0]   r_s1_px;
    logic signed [XW-1:0]    r_s1_py;

    assign len_sum = {1'b0, i_upper} + {1'b0, i_lower};
    assign len_dif = $signed({1'b0, i_upper}) - $signed({1'b0, i_lower});
    assign px_sq   = i_px * i_px;
    assign py_sq   = i_py * i_py;
    assign dif_sq  = len_dif * len_dif;
    assign sum_sq  = len_sum * len_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
        r_s1_zero <= (i_upper == '0) || (i_lower == '0);
        r_s1_px2  <= px_sq[D2W-1:0];
        r_s1_py2  <= D2W'(py_sq[2*XW-2:0]);
        r_s1_s2   <= D2W'(sum_sq);
        r_s1_df2  <= D2W'(dif_sq[2*LW:0]);
        r_s1_u2   <= i_upper * i_upper;
        r_s1_w2   <= i_lower * i_lower;
        r_s1_px   <= i_px;
        r_s1_py   <= i_py;
    end

    // stage 2: distance, reach test, triangle terms
    logic [D2W-1:0]        n_s2_d2;
    logic                  r_s2_vld, r_s2_ok;
    logic [PW-1:0]         r_s2_p, r_s2_q;
    logic signed [NW-1:0]  r_s2_n;
    logic signed [PXW-1:0] r_s2_px;
    logic signed [XW-1:0]  r_s2_py;

    assign n_s2_d2 = r_s1_px2 + r_s1_py2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_ok <= (n_s2_d2 != '0) && !r_s1_zero && (n_s2_d2 <= r_s1_s2)
                   && (n_s2_d2 >= r_s1_df2);
        r_s2_p  <= PW'(r_s1_s2 - n_s2_d2);
        r_s2_q  <= PW'(n_s2_d2 - r_s1_df2);
        r_s2_n  <= NW'(r_s1_u2) - NW'(r_s1_w2) + NW'(n_s2_d2);
        r_s2_px <= r_s1_px;
        r_s2_py <= r_s1_py;
    end

    // square roots, one bit per cell
    logic [1:0][RAD_W-1:0]  sq_rem  [SQRT_W+1];
    logic [1:0][SQRT_W-1:0] sq_root [SQRT_W+1];

    assign sq_rem[0]  = {{r_s2_q, {(RAD_W-PW){1'b0}}}, {r_s2_p, {(RAD_W-PW){1'b0}}}};
    assign sq_root[0] = '0;

    for (genvar g = 0; g < SQRT_W; g++) begin : g_sqrt
        fbik_sqrt_cell #(.BIT(SQRT_W - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1])
        );
    end

    logic                  r_sq_vld [SQRT_W];
    logic                  r_sq_ok  [SQRT_W];
    logic signed [NW-1:0]  r_sq_n   [SQRT_W];
    logic signed [PXW-1:0] r_sq_px  [SQRT_W];
    logic signed [XW-1:0]  r_sq_py  [SQRT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '{default: 1'b0};
        end else begin
            r_sq_vld[0] <= r_s2_vld;
            for (int k = 1; k < SQRT_W; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
        end
        r_sq_ok[0] <= r_s2_ok;
        r_sq_n[0]  <= r_s2_n;
        r_sq_px[0] <= r_s2_px;
        r_sq_py[0] <= r_s2_py;
        for (int k = 1; k < SQRT_W; k++) begin
            r_sq_ok[k] <= r_sq_ok[k-1];
            r_sq_n[k]  <= r_sq_n[k-1];
            r_sq_px[k] <= r_sq_px[k-1];
            r_sq_py[k] <= r_sq_py[k-1];
        end
    end

    // stage 3: height product and scaled vectors; lane 0 base, lane 1 direction
    logic                 r_s3_vld, r_s3_ok;
    logic signed [DW-1:0] r_s3_x [2];
    logic signed [DW-1:0] r_s3_y [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_sq_vld[SQRT_W-1];
        end
        r_s3_ok   <= r_sq_ok[SQRT_W-1];
        r_s3_x[0] <= DW'(r_sq_n[SQRT_W-1]) <<< N_SCALE;
        r_s3_y[0] <= DW'(sq_root[SQRT_W][0] * sq_root[SQRT_W][1]);
        r_s3_x[1] <= DW'(r_sq_px[SQRT_W-1]) <<< DIR_SCALE;
        r_s3_y[1] <= DW'(r_sq_py[SQRT_W-1]) <<< DIR_SCALE;
    end

    // stage 4: quadrant pre-rotation
    logic signed [DW-1:0] n_s4_x [2];
    logic signed [DW-1:0] n_s4_y [2];
    logic signed [ZW-1:0] n_s4_z [2];
    logic                 r_s4_vld, r_s4_ok;
    logic signed [DW-1:0] r_s4_x [2];
    logic signed [DW-1:0] r_s4_y [2];
    logic signed [ZW-1:0] r_s4_z [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_s3_x[l][DW-1]) begin
                if (!r_s3_y[l][DW-1]) begin
                    n_s4_x[l] = r_s3_y[l];
                    n_s4_y[l] = -r_s3_x[l];
                    n_s4_z[l] = HALF_PI_F;
                end else begin
                    n_s4_x[l] = -r_s3_y[l];
                    n_s4_y[l] = r_s3_x[l];
                    n_s4_z[l] = -HALF_PI_F;
                end
            end else begin
                n_s4_x[l] = r_s3_x[l];
                n_s4_y[l] = r_s3_y[l];
                n_s4_z[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        r_s4_ok <= r_s3_ok;
        r_s4_x  <= n_s4_x;
        r_s4_y  <= n_s4_y;
        r_s4_z  <= n_s4_z;
    end

    // CORDIC rows
    logic signed [DW-1:0] cd_x [2][CORDIC_STAGES+1];
    logic signed [DW-1:0] cd_y [2][CORDIC_STAGES+1];
    logic signed [ZW-1:0] cd_z [2][CORDIC_STAGES+1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign cd_x[l][0] = r_s4_x[l];
        assign cd_y[l][0] = r_s4_y[l];
        assign cd_z[l][0] = r_s4_z[l];
        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
            fbik_cordic_cell #(.STAGE(s), .FRAC_BITS(FRAC_BITS)) u_cell (
                .i_clk (i_clk),
                .i_x   (cd_x[l][s]),
                .i_y   (cd_y[l][s]),
                .i_z   (cd_z[l][s]),
                .o_x   (cd_x[l][s+1]),
                .o_y   (cd_y[l][s+1]),
                .o_z   (cd_z[l][s+1])
            );
        end
    end

    logic r_cd_vld [CORDIC_STAGES];
    logic r_cd_ok  [CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_vld <= '{default: 1'b0};
        end else begin
            r_cd_vld[0] <= r_s4_vld;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_cd_vld[k] <= r_cd_vld[k-1];
            end
        end
        r_cd_ok[0] <= r_s4_ok;
        for (int k = 1; k < CORDIC_STAGES; k++) begin
            r_cd_ok[k] <= r_cd_ok[k-1];
        end
    end

    // stage 5: elbow angle and wrap
    logic signed [ZW-1:0] n_s5_sum, n_s5_ang;
    logic                 r_s5_vld, r_s5_ok;
    logic signed [ZW-1:0] r_s5_ang;

    always_comb begin
        if (ADD_BASE) begin
            n_s5_sum = cd_z[1][CORDIC_STAGES] + cd_z[0][CORDIC_STAGES];
        end else begin
            n_s5_sum = cd_z[1][CORDIC_STAGES] - cd_z[0][CORDIC_STAGES];
        end
        if (n_s5_sum > PI_F) begin
            n_s5_ang = n_s5_sum - (PI_F <<< 1);
        end else if (n_s5_sum <= -PI_F) begin
            n_s5_ang = n_s5_sum + (PI_F <<< 1);
        end else begin
            n_s5_ang = n_s5_sum;
        end
    end

    // stages 6 to 10: angle to counts
    logic signed [VW-1:0]  v_s6;
    logic signed [MW-1:0]  n_s7_m;
    logic [MW:0]           n_s9_sum;
    logic [RNDW-1:0]       n_s9_mag;
    logic signed [CLW-1:0] n_s10_c;
    logic [CNTW-1:0]       n_s10_cnt;

    logic                  r_s6_vld, r_s6_ok, r_s7_vld, r_s7_ok, r_s8_vld, r_s8_ok;
    logic                  r_s9_vld, r_s9_ok, r_s10_vld, r_s10_ok;
    logic signed [PRW-1:0] r_s6_prod;
    logic signed [MW-1:0]  r_s7_m;
    logic                  r_s8_neg;
    logic [MW-1:0]         r_s8_mag;
    logic signed [RNDW:0]  r_s9_r;
    logic [CNTW-1:0]       r_s10_cnt;

    assign v_s6     = VW'(r_s6_prod >>> 15);
    assign n_s7_m   = v_s6 * CPHT;
    assign n_s9_sum = {1'b0, r_s8_mag} + RND_HALF;
    assign n_s9_mag = RNDW'(n_s9_sum >> (FRAC_BITS + 15));

    always_comb begin
        n_s10_c = CLW'($signed({1'b0, i_centre})) - CLW'(r_s9_r);
        if (n_s10_c[CLW-1]) begin
            n_s10_cnt = '0;
        end else if (n_s10_c > CLW'(COUNT_MAX)) begin
            n_s10_cnt = COUNT_MAX;
        end else begin
            n_s10_cnt = n_s10_c[CNTW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
        end else begin
            r_s5_vld  <= r_cd_vld[CORDIC_STAGES-1];
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
        end
        r_s5_ok   <= r_cd_ok[CORDIC_STAGES-1];
        r_s6_ok   <= r_s5_ok;
        r_s7_ok   <= r_s6_ok;
        r_s8_ok   <= r_s7_ok;
        r_s9_ok   <= r_s8_ok;
        r_s10_ok  <= r_s9_ok;
        r_s5_ang  <= n_s5_ang;
        r_s6_prod <= r_s5_ang * INV_PI;
        r_s7_m    <= n_s7_m;
        r_s8_neg  <= r_s7_m[MW-1];
        r_s8_mag  <= r_s7_m[MW-1] ? MW'(-r_s7_m) : MW'(r_s7_m);
        r_s9_r    <= r_s8_neg ? -$signed({1'b0, n_s9_mag}) : $signed({1'b0, n_s9_mag});
        r_s10_cnt <= n_s10_cnt;
    end

    assign o_res.vld   = r_s10_vld;
    assign o_res.ok    = r_s10_ok;
    assign o_res.count = r_s10_cnt;
endmodule
`default_nettype wire

>>> rtl/five_bar_inverse_kinematics.sv
`default_nettype none
// Five-bar linkage inverse kinematics, fully pipelined.
// Input: pulse i_start with i_x_pos / i_y_pos (signed, 2^-16 m); a beat is
// taken at every edge where i_start is high and o_busy is low. o_busy is low
// except during reset, so one beat per cycle is sustained.
// Output: o_done is high for one cycle per beat with o_reachable,
// o_left_count and o_right_count. Results come out in order; the pipeline
// holds the 29 cells of the bit-serial square root row and the
// CORDIC_STAGES cells of each angle row.
// The receiver cannot stall; every beat produces exactly one o_done.
// Unreachable targets give o_reachable low and zero counts.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// write only while no beat is in flight. Unknown indexes are ignored.
// Reset (synchronous, active low) restores the default link lengths, base
// offset and centre count and drops all beats in flight.
module five_bar_inverse_kinematics #(
    parameter int FRAC_BITS            = 16,
    parameter int CORDIC_STAGES        = 16,
    parameter int COUNTS_PER_HALF_TURN = 2048
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [fbik_pkg::XW-1:0]       i_x_pos,
    input  logic signed [fbik_pkg::XW-1:0]       i_y_pos,
    output logic                                 o_done,
    output logic                                 o_reachable,
    output logic [fbik_pkg::CNTW-1:0]            o_left_count,
    output logic [fbik_pkg::CNTW-1:0]            o_right_count,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fbik_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fbik_pkg::LW-1:0]              i_cfg_data
);
    import fbik_pkg::*;
    localparam int LATENCY = SQRT_W + CORDIC_STAGES + 12;

    logic [LW-1:0]   r_lu, r_ll, r_rl, r_ru, r_off;
    logic [CNTW-1:0] r_centre;
    logic            accept;

    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lu     <= 16'd11141;
            r_ll     <= 16'd11141;
            r_rl     <= 16'd11141;
            r_ru     <= 16'd11141;
            r_off    <= 16'd6554;
            r_centre <= 13'd3072;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LEFT_UPPER:  r_lu     <= i_cfg_data;
                CFG_LEFT_LOWER:  r_ll     <= i_cfg_data;
                CFG_RIGHT_LOWER: r_rl     <= i_cfg_data;
                CFG_RIGHT_UPPER: r_ru     <= i_cfg_data;
                CFG_BASE_OFFSET: r_off    <= i_cfg_data;
                CFG_CENTRE:      r_centre <= i_cfg_data[CNTW-1:0];
                default: ;
            endcase
        end
    end

    logic                  r_vld;
    logic signed [PXW-1:0] r_px_l, r_px_r;
    logic signed [XW-1:0]  r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
        r_px_l <= PXW'(i_x_pos);
        r_px_r <= PXW'(i_x_pos) + $signed({2'b00, r_off});
        r_py   <= i_y_pos;
    end

    t_arm_res res_l, res_r;

    fbik_arm #(
        .FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES),
        .COUNTS_PER_HALF_TURN(COUNTS_PER_HALF_TURN), .ADD_BASE(1'b0)
    ) u_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vld), .i_px(r_px_l), .i_py(r_py),
        .i_upper(r_lu), .i_lower(r_ll), .i_centre(r_centre), .o_res(res_l)
    );

    fbik_arm #(
        .FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES),
        .COUNTS_PER_HALF_TURN(COUNTS_PER_HALF_TURN), .ADD_BASE(1'b1)
    ) u_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vld), .i_px(r_px_r), .i_py(r_py),
        .i_upper(r_ru), .i_lower(r_rl), .i_centre(r_centre), .o_res(res_r)
    );

    logic            r_done, r_reach;
    logic [CNTW-1:0] r_lc, r_rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res_l.vld;
        end
        r_reach <= res_l.ok && res_r.ok;
        r_lc    <= (res_l.ok && res_r.ok) ? res_l.count : '0;
        r_rc    <= (res_l.ok && res_r.ok) ? res_r.count : '0;
    end

    assign o_done        = r_done;
    assign o_reachable   = r_reach;
    assign o_left_count  = r_lc;
    assign o_right_count = r_rc;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("result beat missing");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result beat without input beat");
    a_arms_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_l.vld == res_r.vld)
        else $error("arm pipelines out of step");
    a_zero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_reachable |-> o_left_count == '0 && o_right_count == '0)
        else $error("nonzero count for unreachable target");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fbik_pkg::*;

    localparam int STAGES     = 16;
    localparam int HALF_COUNT = 2048;
    localparam int LATENCY    = 57;
    localparam int WD_LIMIT   = 4000;

    typedef struct packed {
        logic            reachable;
        logic [CNTW-1:0] left_count;
        logic [CNTW-1:0] right_count;
    } t_joint_counts;

    class ik_scoreboard;
        longint        lu, ll, rl, ru, off, centre;
        t_joint_counts pending[$];
        int            errors, n_reach, n_unreach;

        function new();
            reset_regs();
            errors = 0;
            n_reach = 0;
            n_unreach = 0;
        endfunction

        function void reset_regs();
            lu = 11141; ll = 11141; rl = 11141; ru = 11141; off = 6554; centre = 3072;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [LW-1:0] val);
            case (idx)
                CFG_LEFT_UPPER:  lu = longint'(val);
                CFG_LEFT_LOWER:  ll = longint'(val);
                CFG_RIGHT_LOWER: rl = longint'(val);
                CFG_RIGHT_UPPER: ru = longint'(val);
                CFG_BASE_OFFSET: off = longint'(val);
                CFG_CENTRE:      centre = longint'(val[CNTW-1:0]);
                default: ;
            endcase
        endfunction

        function longint q30_frac(longint q30);
            return (q30 + (64'sd1 << 13)) >>> 14;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint vector_angle(longint x, longint y);
            longint z, t, sx, sy;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = q30_frac(HALF_PI_Q30);
                end else begin
                    x = -y; y = t; z = -q30_frac(HALF_PI_Q30);
                end
            end
            for (int i = 0; i < STAGES; i++) begin
                sx = x >>> i;
                sy = y >>> i;
                if (y > 0) begin
                    x += sy; y -= sx; z += q30_frac(ATAN_Q30[i]);
                end else begin
                    x -= sy; y += sx; z -= q30_frac(ATAN_Q30[i]);
                end
            end
            return z;
        endfunction

        function bit elbow_angle(longint px, longint py, longint up, longint lo,
                                 bit ccw, output longint ang);
            longint d2, s, df, p, q, n, h, a, pi_f;
            d2 = px * px + py * py;
            s = up + lo;
            df = up - lo;
            ang = 0;
            if (d2 == 0 || up == 0 || lo == 0) return 0;
            if (d2 > s * s || d2 < df * df) return 0;
            p = s * s - d2;
            q = d2 - df * df;
            n = up * up - lo * lo + d2;
            h = int_sqrt(p << 24) * int_sqrt(q << 24);
            a = vector_angle(px * (64'sd1 << 30), py * (64'sd1 << 30));
            if (ccw) a += vector_angle(n * (64'sd1 << 24), h);
            else     a -= vector_angle(n * (64'sd1 << 24), h);
            pi_f = q30_frac(PI_Q30);
            if (a > pi_f) a -= 2 * pi_f;
            else if (a <= -pi_f) a += 2 * pi_f;
            ang = a;
            return 1;
        endfunction

        function logic [CNTW-1:0] servo_count(longint ang);
            longint v, m, r, c;
            longint unsigned mag;
            v = (ang * longint'(INV_PI_Q30)) >>> 15;
            m = v * HALF_COUNT;
            mag = (m < 0) ? -m : m;
            r = (mag + (64'd1 << 30)) >> 31;
            if (m < 0) r = -r;
            c = centre - r;
            if (c < 0) c = 0;
            if (c > COUNT_MAX) c = COUNT_MAX;
            return c[CNTW-1:0];
        endfunction

        function void note_target(logic signed [XW-1:0] x, logic signed [XW-1:0] y);
            t_joint_counts e;
            longint xl, yl, la, ra;
            bit ok;
            xl = longint'(x);
            yl = longint'(y);
            ok = elbow_angle(xl, yl, lu, ll, 0, la);
            if (ok) ok = elbow_angle(xl + off, yl, ru, rl, 1, ra);
            e = '0;
            if (ok) begin
                e.reachable = 1;
                e.left_count = servo_count(la);
                e.right_count = servo_count(ra);
                n_reach++;
            end else begin
                n_unreach++;
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic r, logic [CNTW-1:0] lc, logic [CNTW-1:0] rc);
            t_joint_counts e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result reach=%0d left=%0d right=%0d",
                         $time, r, lc, rc);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r !== e.reachable) begin
                $display("%0t: reachable exp %0d act %0d", $time, e.reachable, r);
                errors++;
            end
            if (lc !== e.left_count) begin
                $display("%0t: left_count exp %0d act %0d", $time, e.left_count, lc);
                errors++;
            end
            if (rc !== e.right_count) begin
                $display("%0t: right_count exp %0d act %0d", $time, e.right_count, rc);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_start = 0;
    logic                   o_busy;
    logic signed [XW-1:0]   i_x_pos = '0;
    logic signed [XW-1:0]   i_y_pos = '0;
    logic                   o_done;
    logic                   o_reachable;
    logic [CNTW-1:0]        o_left_count;
    logic [CNTW-1:0]        o_right_count;
    logic                   i_cfg_valid = 0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [LW-1:0]          i_cfg_data = '0;

    ik_scoreboard sb = new();
    int  idle_calm = 0;
    int  stalled = 0;

    five_bar_inverse_kinematics u_top (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_x_pos, .i_y_pos,
        .o_done, .o_reachable, .o_left_count, .o_right_count,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
                stalled <= 0;
            end else begin
                stalled <= stalled + 1;
            end
            if (i_start && !o_busy) begin
                sb.note_target(i_x_pos, i_y_pos);
            end
            if (o_done) begin
                sb.check_result(o_reachable, o_left_count, o_right_count);
            end
            if (stalled >= WD_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_target(int x, int y);
        i_start = 1;
        i_x_pos = XW'(x);
        i_y_pos = XW'(y);
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        if (idle_calm == 0 && $urandom_range(99) < 22) begin
            i_start = 0;
            i_x_pos = XW'($urandom);
            i_y_pos = XW'($urandom);
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [LW-1:0] val);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic drain();
        i_start = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic load_arms(int a, int b, int c, int d, int o, int ctr);
        drain();
        write_reg(CFG_LEFT_UPPER, LW'(a));
        write_reg(CFG_LEFT_LOWER, LW'(b));
        write_reg(CFG_RIGHT_LOWER, LW'(c));
        write_reg(CFG_RIGHT_UPPER, LW'(d));
        write_reg(CFG_BASE_OFFSET, LW'(o));
        write_reg(CFG_CENTRE, LW'(ctr));
    endtask

    function automatic int clamp_pos(real v);
        if (v > 65535.0) return 65535;
        if (v < -65536.0) return -65536;
        return $rtoi(v);
    endfunction

    // Mostly targets inside the left arm's annulus, shifted now and then toward
    // the right base; the rest are raw noise over the full field range.
    task automatic random_targets(int count);
        real r, th, rmin, rmax, cx;
        for (int k = 0; k < count; k++) begin
            idle_calm = (k >= count / 3 && k < count / 2);
            if ($urandom_range(99) < 75) begin
                rmax = real'(sb.lu + sb.ll);
                rmin = (sb.lu > sb.ll) ? real'(sb.lu - sb.ll) : real'(sb.ll - sb.lu);
                r = rmin + (rmax - rmin) * ($urandom_range(10000) / 10000.0);
                th = 6.283185307 * ($urandom_range(10000) / 10000.0);
                cx = ($urandom_range(3) == 0) ? -real'(sb.off) / 2.0 : 0.0;
                send_target(clamp_pos(cx + r * $cos(th)), clamp_pos(r * $sin(th)));
            end else begin
                send_target($urandom, $urandom);
            end
        end
        idle_calm = 0;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        send_target(0, 0);
        send_target(-65536, -65536);
        send_target(65535, 65535);
        send_target(-65536, 65535);
        send_target(65535, -65536);
        send_target(-3277, 15000);
        send_target(-3277, -15000);
        send_target(0, 22282);
        send_target(0, 22283);
        send_target(22282, 0);
        send_target(-28836, 0);
        send_target(-6554, 0);
        send_target(-6554, 1);
        send_target(10000, 10000);
        send_target(-20000, 5000);
        send_target(-3277, 1);
        random_targets(240);

        load_arms(65535, 65535, 65535, 65535, 65535, 6143);
        send_target(65535, 65535);
        send_target(-65536, 65535);
        send_target(-32768, -40000);
        random_targets(240);

        load_arms(1, 1, 1, 1, 0, 2048);
        send_target(0, 0);
        send_target(1, 1);
        send_target(2, 0);
        send_target(-1, 1);
        random_targets(200);

        load_arms(20000, 5000, 3000, 30000, 30000, 4000);
        random_targets(240);

        for (int p = 0; p < 2; p++) begin
            load_arms($urandom_range(1, 65535), $urandom_range(1, 65535),
                      $urandom_range(1, 65535), $urandom_range(1, 65535),
                      $urandom_range(0, 65535), $urandom_range(2048, 6143));
            random_targets(240);
        end

        load_arms(11141, 11141, 11141, 11141, 6554, 3072);
        random_targets(150);

        drain();
        $display("targets sent: %0d reachable, %0d unreachable, over 7 arm settings",
                 sb.n_reach, sb.n_unreach);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
